>>> rtl/lzmf_pkg.sv
// Package with shared types and codes for the LZ77 candidate match finder.
`default_nettype none
package lzmf_pkg;
	typedef enum logic [1:0] {
		MODE_WRITE  = 2'd0,
		MODE_APPEND = 2'd1,
		MODE_DROP   = 2'd2,
		MODE_QUERY  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RD,
		ST_CMP,
		ST_NEXT,
		ST_DONE
	} state_t;

	localparam int unsigned LEN_W = 9;
	localparam int unsigned POS_W = 12;
	localparam int unsigned BYTE_W = 8;
endpackage
`default_nettype wire

>>> rtl/lzmf_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module lzmf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

>>> rtl/lzmf_cell.sv
// One cell of the candidate chain: holds a candidate position and passes it on.
`default_nettype none
module lzmf_cell
	import lzmf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             load,
	input  wire logic             shift,
	input  wire logic [POS_W-1:0] load_pos,
	input  wire logic [POS_W-1:0] prev_pos,
	output logic      [POS_W-1:0] pos_q
);
	always_ff @(posedge clk) begin
		if (load) begin
			pos_q <= load_pos;
		end else if (shift) begin
			pos_q <= prev_pos;
		end
	end
endmodule
`default_nettype wire

>>> rtl/lz77_candidate_match_finder_unit.sv
// Top level of the LZ77 candidate match finder.
`default_nettype none
// Command-style block. A beat is taken when start is high and busy is low.
// History writes, appends and drops give no result and leave busy low, so they
// can follow each other with no gap.
// A query walks the candidates oldest first through a row of cells that rotate
// one place per candidate. Each compared byte passes a read step, a latch step
// and a compare step: the first issues the candidate byte read, the second
// latches that byte and issues the lookahead byte read, and the third compares
// (registered reads from a single history RAM port). A candidate ends when a
// byte mismatches or when the length limit is reached. The single history RAM
// port sets the pace of the walk. The result appears for one cycle on done, in
// the last busy cycle; the receiver cannot stall, so no backpressure exists.
// There is no clearing pass: history is undefined until written.
module lz77_candidate_match_finder_unit
	import lzmf_pkg::*;
#(
	parameter int unsigned WINDOW_BYTES = 4096,
	parameter int unsigned MAX_CANDIDATES = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        mode,
	input  wire logic [POS_W-1:0]  position,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              cfg_we,
	input  wire logic [LEN_W-1:0]  cfg_wdata,
	output logic                   done,
	output logic [POS_W-1:0]       match_position,
	output logic [LEN_W-1:0]       match_length
);
	localparam int unsigned AW = $clog2(WINDOW_BYTES);
	localparam int unsigned CW = $clog2(MAX_CANDIDATES + 1);
	localparam int unsigned N = MAX_CANDIDATES;

	state_t state_q, state_d;
	logic [LEN_W-1:0] max_len_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] walk_q;
	logic [LEN_W-1:0] n_q;
	logic [POS_W-1:0] look_q;
	logic [BYTE_W-1:0] cand_byte_q;
	logic phase_q;
	logic [POS_W-1:0] best_pos_q;
	logic [LEN_W-1:0] best_len_q;
	logic [POS_W-1:0] cells [N];
	logic accept;
	logic do_append, do_drop, full, shift, load_tail;
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [BYTE_W-1:0] ram_rdata;
	logic [POS_W-1:0] cand_pos;
	logic [CW-1:0] tail_idx;

	assign accept = start && !busy;
	assign full = (count_q == CW'(N));
	assign do_append = accept && (mode == MODE_APPEND);
	assign do_drop = accept && (mode == MODE_DROP) && (count_q != '0);
	assign cand_pos = cells[0];
	assign load_tail = do_append;

	// Outside a query walk, cell 0 holds the oldest candidate. A drop rotates by one; a query
	// rotates the whole active set once, one step per finished candidate.
	assign shift = do_drop || (do_append && full) || (state_q == ST_NEXT);
	// An append loads the cell just after the newest entry, after any shift.
	assign tail_idx = full ? CW'(N - 1) : count_q;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [POS_W-1:0] prev;
		logic ld;
		if (i == N - 1) begin : g_last
			assign prev = cells[0];
		end else begin : g_mid
			// During a query walk the oldest entry must land after the active
			// set, so cell count-1 takes cell 0 instead of its neighbor.
			assign prev = ((state_q == ST_NEXT) && (CW'(i) == count_q - CW'(1))) ?
				cells[0] : cells[i+1];
		end
		assign ld = load_tail && (tail_idx == CW'(i));
		lzmf_cell u_cell (
			.clk(clk), .load(ld), .shift(shift && !ld),
			.load_pos(position), .prev_pos(prev), .pos_q(cells[i])
		);
	end

	// History RAM address: writes, then candidate byte (read state) or
	// lookahead byte (compare state). Sums are formed wide and wrap at the window.
	assign ram_we = accept && (mode == MODE_WRITE);
	always_comb begin
		if (state_q == ST_IDLE) begin
			ram_addr = AW'(position);
		end else if (state_q != ST_CMP) begin
			ram_addr = AW'(32'(cand_pos) + 32'(n_q));
		end else begin
			ram_addr = AW'(32'(look_q) + 32'(n_q));
		end
	end

	lzmf_ram #(.WIDTH(BYTE_W), .DEPTH(WINDOW_BYTES)) u_hist (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(data_byte), .rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && (mode == MODE_QUERY)) state_d = ST_LOAD;
			ST_LOAD: state_d = (walk_q == '0) ? ST_DONE : ST_RD;
			ST_RD: state_d = (n_q >= max_len_q) ? ST_NEXT : ST_CMP;
			ST_CMP: state_d = phase_q ? ST_RD : ST_CMP;
			ST_NEXT: state_d = (walk_q == CW'(1)) ? ST_DONE : ST_RD;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE);
		match_position = best_pos_q;
		match_length = best_len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_len_q <= LEN_W'(18);
			count_q <= '0;
			walk_q <= '0;
			n_q <= '0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) max_len_q <= cfg_wdata;
			if (do_append && !full) count_q <= count_q + CW'(1);
			if (do_drop) count_q <= count_q - CW'(1);
			unique case (state_q)
				ST_IDLE: begin
					walk_q <= count_q;
					n_q <= '0;
					phase_q <= 1'b0;
				end
				ST_RD: phase_q <= 1'b0;
				ST_CMP: begin
					// In phase 0 the candidate byte is latched while the lookahead
					// read is issued; in phase 1 the two bytes are compared.
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						if (ram_rdata == cand_byte_q) begin
							n_q <= n_q + LEN_W'(1);
						end else begin
							n_q <= max_len_q;
						end
					end
				end
				ST_NEXT: begin
					walk_q <= walk_q - CW'(1);
					n_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Compare datapath registers; best is updated when a candidate finishes.
	logic [LEN_W-1:0] len_run_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			look_q <= position;
			best_pos_q <= '0;
			best_len_q <= '0;
			len_run_q <= '0;
		end
		if (state_q == ST_CMP && !phase_q) cand_byte_q <= ram_rdata;
		if (state_q == ST_CMP && phase_q && ram_rdata == cand_byte_q) begin
			len_run_q <= n_q + LEN_W'(1);
		end
		if (state_q == ST_NEXT) begin
			if (len_run_q > best_len_q) begin
				best_len_q <= len_run_q;
				best_pos_q <= cand_pos;
			end
			len_run_q <= '0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(N))
		else $error("candidate count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("busy after result");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> $stable(count_q))
		else $error("count changed during query");
endmodule
`default_nettype wire
